// ===== src/rkc_pkg.sv =====
// shared constants and types for the substring counter
package rkc_pkg;

  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_INDEX_BITS  = 16;

  localparam int PAT_BYTES  = 16;
  localparam int PAT_W      = PAT_BYTES * 8;
  localparam int LEN_W      = 5;
  localparam int COUNT_W    = 16;
  localparam int FIELD_IX_W = 16;
  localparam int CFG_IX_W   = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

  typedef struct packed {
    logic accept;
    logic clear;
    logic window_eq;
  } rkc_step_t;

  typedef struct packed {
    logic                  hit;
    logic [COUNT_W-1:0]    count;
    logic                  found;
    logic [FIELD_IX_W-1:0] first_idx;
  } rkc_result_t;

endpackage

// ===== src/rkc_cell.sv =====
// one window byte with its compare against the aligned pattern byte
module rkc_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic                     clear_i,
  input  logic [7:0]               byte_i,
  input  logic [rkc_pkg::PAT_W-1:0] pattern_i,
  input  logic [rkc_pkg::LEN_W-1:0] len_i,
  output logic [7:0]               byte_o,
  output logic                     eq_o
);
  import rkc_pkg::*;

  localparam logic [LEN_W-1:0] MyIdx = LEN_W'(CELL_IDX);

  logic [7:0]       byte_q, byte_d;
  logic [LEN_W-1:0] pat_sel;
  logic [7:0]       pat_byte;

  // cell k faces pattern byte len-1-k
  assign pat_sel  = len_i - MyIdx - LEN_W'(1);
  assign pat_byte = pattern_i[pat_sel[3:0]*8 +: 8];
  assign eq_o     = (MyIdx >= len_i) || (byte_i == pat_byte);

  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = clear_i ? 8'd0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== src/rkc_match_track.sv =====
// position, overlap, count and first-match tracking
module rkc_match_track #(
  parameter int INDEX_BITS = rkc_pkg::DEF_INDEX_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rkc_pkg::rkc_step_t        step_i,
  input  logic [rkc_pkg::LEN_W-1:0] len_i,
  output rkc_pkg::rkc_result_t      result_o
);
  import rkc_pkg::*;

  localparam int POS_W = INDEX_BITS + 1;
  localparam logic [POS_W-1:0]      PosMax   = {POS_W{1'b1}};
  localparam logic [INDEX_BITS-1:0] StartMax = {INDEX_BITS{1'b1}};

  logic [POS_W-1:0]      pos_q, pos_d, pos_next;
  logic [POS_W-1:0]      last_end_q, last_end_d, last_end_upd;
  logic [COUNT_W-1:0]    count_q, count_d, count_upd;
  logic                  found_q, found_d, found_upd;
  logic [INDEX_BITS-1:0] first_q, first_d, first_upd;
  logic [POS_W-1:0]      len_ext, start;
  logic                  allowed, hit;

  assign pos_next = (pos_q == PosMax) ? pos_q : pos_q + POS_W'(1);
  assign len_ext  = POS_W'(len_i);
  assign start    = pos_next - len_ext;
  assign allowed  = (len_i != '0) && (pos_next >= len_ext) && (last_end_q <= start);
  assign hit      = allowed && step_i.window_eq;

  always_comb begin
    count_upd    = count_q;
    last_end_upd = last_end_q;
    found_upd    = found_q;
    first_upd    = first_q;
    if (hit) begin
      if (count_q != {COUNT_W{1'b1}}) begin
        count_upd = count_q + COUNT_W'(1);
      end
      last_end_upd = pos_next;
      if (!found_q) begin
        found_upd = 1'b1;
        first_upd = (start > POS_W'(StartMax)) ? StartMax : start[INDEX_BITS-1:0];
      end
    end
  end

  always_comb begin
    pos_d      = pos_q;
    last_end_d = last_end_q;
    count_d    = count_q;
    found_d    = found_q;
    first_d    = first_q;
    if (step_i.accept) begin
      if (step_i.clear) begin
        pos_d      = '0;
        last_end_d = '0;
        count_d    = '0;
        found_d    = 1'b0;
        first_d    = '0;
      end else begin
        pos_d      = pos_next;
        last_end_d = last_end_upd;
        count_d    = count_upd;
        found_d    = found_upd;
        first_d    = first_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      last_end_q <= '0;
      count_q    <= '0;
      found_q    <= 1'b0;
      first_q    <= '0;
    end else begin
      pos_q      <= pos_d;
      last_end_q <= last_end_d;
      count_q    <= count_d;
      found_q    <= found_d;
      first_q    <= first_d;
    end
  end

  assign result_o.hit       = hit;
  assign result_o.count     = count_upd;
  assign result_o.found     = found_upd;
  assign result_o.first_idx = found_upd ? FIELD_IX_W'(first_upd) : '0;

endmodule

// ===== src/rabin_karp_substring_counter.sv =====
// top level: cell row, match tracker, config registers and result register
// result: the result of a byte is presented in the cycle after it is accepted
// throughput: one byte per cycle while intake is not stalled, set by the combinational compare across the cell row
// intake stalls only while a held result is itself stalled by the receiver
// reset: window, counters and config clear at once; pattern length resets to one
module rabin_karp_substring_counter #(
  parameter int MAX_PATTERN = rkc_pkg::DEF_MAX_PATTERN,
  parameter int INDEX_BITS  = rkc_pkg::DEF_INDEX_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           end_of_text_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           match_ends_here_o,
  output logic [rkc_pkg::COUNT_W-1:0]    match_count_o,
  output logic                           found_o,
  output logic [rkc_pkg::FIELD_IX_W-1:0] first_match_index_o,
  output logic                           text_done_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rkc_pkg::CFG_IX_W-1:0]   cfg_index_i,
  input  logic [rkc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rkc_pkg::*;

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN);

  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
  logic [LEN_W-1:0]      len_q, len_eff;
  logic [PAT_W-1:0]      pattern;
  logic                  accept;
  logic [7:0]            chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] cell_eq;
  rkc_step_t             step;
  rkc_result_t           result;

  logic                  out_valid_q, out_valid_d;
  logic                  hit_q, found_q, done_q;
  logic [COUNT_W-1:0]    count_q;
  logic [FIELD_IX_W-1:0] first_q;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= LEN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LOW:  pat_lo_q <= cfg_data_i;
        CFG_PATTERN_HIGH: pat_hi_q <= cfg_data_i;
        CFG_PATTERN_LEN:  len_q    <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern = {pat_hi_q, pat_lo_q};
  assign len_eff = (len_q > MaxLen) ? MaxLen : len_q;

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // cell row, newest byte in cell zero
  assign chain[0] = text_byte_i;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    rkc_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .clear_i  (end_of_text_i),
      .byte_i   (chain[k]),
      .pattern_i(pattern),
      .len_i    (len_eff),
      .byte_o   (chain[k+1]),
      .eq_o     (cell_eq[k])
    );
  end

  assign step.accept    = accept;
  assign step.clear     = end_of_text_i;
  assign step.window_eq = &cell_eq;

  rkc_match_track #(
    .INDEX_BITS(INDEX_BITS)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .len_i   (len_eff),
    .result_o(result)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q   <= result.hit;
      count_q <= result.count;
      found_q <= result.found;
      first_q <= result.first_idx;
      done_q  <= end_of_text_i;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign match_ends_here_o   = hit_q;
  assign match_count_o       = count_q;
  assign found_o             = found_q;
  assign first_match_index_o = first_q;
  assign text_done_o         = done_q;

endmodule
